// ===== sv/rme_pkg.sv =====
// Package for the rotation-matrix-to-Euler block.
// Holds widths, the CORDIC arctangent table and the stage types. No dependencies.
package rme_pkg;

    localparam int unsigned ENTRY_W  = 16;
    localparam int unsigned THR_W    = 15;
    localparam int unsigned ANGX_W   = 16;
    localparam int unsigned ANGY_W   = 15;
    localparam int unsigned STEPS    = 16;
    localparam int unsigned CW       = 34;
    localparam int unsigned ACC_W    = 34;
    localparam int unsigned SQ_W     = 32;
    localparam int unsigned SY_W     = 16;
    localparam logic [THR_W-1:0] THR_RESET = 15'd1;
    localparam logic signed [ACC_W-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [ACC_W-1:0] LIM_XZ = 34'sd25736;
    localparam logic signed [ACC_W-1:0] LIM_Y  = 34'sd12868;

    function automatic logic signed [ACC_W-1:0] atan_tab(input logic [3:0] i);
        logic signed [ACC_W-1:0] t;
        case (i)
            4'd0:    t = 34'sd843314856;
            4'd1:    t = 34'sd497837829;
            4'd2:    t = 34'sd263043836;
            4'd3:    t = 34'sd133525158;
            4'd4:    t = 34'sd67021686;
            4'd5:    t = 34'sd33543515;
            4'd6:    t = 34'sd16775850;
            4'd7:    t = 34'sd8388437;
            4'd8:    t = 34'sd4194282;
            4'd9:    t = 34'sd2097149;
            4'd10:   t = 34'sd1048575;
            4'd11:   t = 34'sd524287;
            4'd12:   t = 34'sd262143;
            4'd13:   t = 34'sd131071;
            4'd14:   t = 34'sd65535;
            default: t = 34'sd32767;
        endcase
        return t;
    endfunction

    typedef struct packed {
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
    } cordic_t;

endpackage

// ===== sv/rme_if.sv =====
// Valid/ready channel interfaces for the rotation-matrix-to-Euler block.
// Depends on nothing; the payload widths are fixed in each interface.
interface rme_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    modport source (output valid, r00, r10, r20, r21, r22, r11, r12, input ready);
    modport sink (input valid, r00, r10, r20, r21, r22, r11, r12, output ready);
endinterface

interface rme_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle_x;
    logic signed [14:0] angle_y;
    logic signed [15:0] angle_z;
    logic               singular_flag;
    modport source (output valid, angle_x, angle_y, angle_z, singular_flag, input ready);
    modport sink (input valid, angle_x, angle_y, angle_z, singular_flag, output ready);
endinterface

interface rme_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== sv/rme_cordic_step.sv =====
// One vectoring iteration of the CORDIC arctangent, combinational.
// Depends on rme_pkg.
module rme_cordic_step #(
    parameter logic [3:0] IDX = 4'd0
) (
    input  rme_pkg::cordic_t d,
    output rme_pkg::cordic_t q
);
    logic signed [rme_pkg::CW-1:0] dx;
    logic signed [rme_pkg::CW-1:0] dy;

    assign dx = d.y >>> IDX;
    assign dy = d.x >>> IDX;

    always_comb
    begin
        q = d;
        if (d.y > 0)
        begin
            q.x   = d.x + dx;
            q.y   = d.y - dy;
            q.acc = d.acc + rme_pkg::atan_tab(IDX);
        end
        else
        begin
            q.x   = d.x - dx;
            q.y   = d.y + dy;
            q.acc = d.acc - rme_pkg::atan_tab(IDX);
        end
    end
endmodule

// ===== sv/rotation_matrix_to_euler_top.sv =====
// Top level: ZYX Euler angles from a rotation matrix, fully pipelined.
// Depends on rme_pkg, rme_if and rme_cordic_step.
//
//  channel  | dir | transfer carries
//  in_ch    | in  | r00 r10 r20 r21 r22 r11 r12 (Q1.15)
//  out_ch   | out | angle_x angle_z (Q3.13), angle_y (Q2.13), singular_flag
//  cfg_ch   | in  | singular_threshold (Q0.15)
//
// One item per cycle while the output is not stalled. The pipeline has 35 register
// stages: square sum, 16 square root stages (one result bit each), prescale,
// 16 CORDIC stages on three parallel chains, output register.
// Reset clears all valid bits and sets the threshold to 1. A stall freezes every
// stage; ready is the output stage's space.
module rotation_matrix_to_euler_top (
    input  logic clk,
    input  logic rst_n,
    rme_in_if.sink    in_ch,
    rme_out_if.source out_ch,
    rme_cfg_if.sink   cfg_ch
);
    localparam int unsigned NS = 16;          // sqrt stages
    localparam int unsigned ND = NS + 2 + rme_pkg::STEPS;

    typedef struct packed {
        logic signed [15:0] r10, r00, r20, r21, r22, r11, r12;
        logic [rme_pkg::SQ_W-1:0] rem;
        logic [rme_pkg::SY_W:0]   root;
    } sq_t;

    logic [rme_pkg::THR_W-1:0] thr_reg;
    logic advance;
    logic [ND-1:0] vld_reg;
    sq_t sq_reg [NS+1];
    sq_t sq_next [NS+1];
    rme_pkg::cordic_t ca_reg [rme_pkg::STEPS+1];
    rme_pkg::cordic_t cb_reg [rme_pkg::STEPS+1];
    rme_pkg::cordic_t cc_reg [rme_pkg::STEPS+1];
    rme_pkg::cordic_t ca_next [rme_pkg::STEPS];
    rme_pkg::cordic_t cb_next [rme_pkg::STEPS];
    rme_pkg::cordic_t cc_next [rme_pkg::STEPS];
    logic sing_reg [rme_pkg::STEPS+1];
    logic signed [15:0] ax_reg, az_reg;
    logic signed [14:0] ay_reg;
    logic sing_out_reg;
    logic out_vld_reg;

    assign advance      = !out_vld_reg || out_ch.ready;
    assign in_ch.ready  = advance;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= rme_pkg::THR_RESET;
        else if (cfg_ch.valid)
            thr_reg <= cfg_ch.data;
    end

    // square root, one result bit per stage (restoring)
    for (genvar s = 0; s < NS; s++)
    begin : g_sqrt
        logic [rme_pkg::SQ_W+1:0] trial;
        always_comb
        begin
            sq_next[s+1] = sq_reg[s];
            trial = {2'b00, sq_reg[s].rem} - ({2'b00, {15'd0, sq_reg[s].root} << (32 - 2*s)}
                    + (34'd1 << (30 - 2*s)));
            // classic form: test (root<<2 | 1) at bit pair
            if (trial[rme_pkg::SQ_W+1] == 1'b0)
            begin
                sq_next[s+1].rem  = trial[rme_pkg::SQ_W-1:0];
                sq_next[s+1].root = (sq_reg[s].root << 1) | 17'd1;
            end
            else
                sq_next[s+1].root = sq_reg[s].root << 1;
        end
    end

    always_comb
    begin
        logic signed [31:0] p0, p1;
        p0 = in_ch.r00 * in_ch.r00;
        p1 = in_ch.r10 * in_ch.r10;
        sq_next[0].r00 = in_ch.r00;
        sq_next[0].r10 = in_ch.r10;
        sq_next[0].r20 = in_ch.r20;
        sq_next[0].r21 = in_ch.r21;
        sq_next[0].r22 = in_ch.r22;
        sq_next[0].r11 = in_ch.r11;
        sq_next[0].r12 = in_ch.r12;
        sq_next[0].rem = 32'(p0) + 32'(p1);
        sq_next[0].root = '0;
    end

    function automatic rme_pkg::cordic_t pre(input logic signed [16:0] yv,
                                             input logic signed [16:0] xv);
        rme_pkg::cordic_t c;
        c.x = 34'(xv) <<< 14;
        c.y = 34'(yv) <<< 14;
        c.acc = '0;
        c.zero = (xv == 0) && (yv == 0);
        if (xv < 0)
        begin
            c.acc = (yv >= 0) ? rme_pkg::PI_Q30 : -rme_pkg::PI_Q30;
            c.x = -c.x;
            c.y = -c.y;
        end
        return c;
    endfunction

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s <= NS; s++)
                sq_reg[s] <= sq_next[s];
        end
    end

    // prescale stage
    logic sing_w;
    logic [16:0] sy_w;
    assign sy_w   = sq_reg[NS].root;
    assign sing_w = sy_w < {2'b00, thr_reg};

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sing_reg[0] <= sing_w;
            ca_reg[0] <= sing_w ? pre(-17'(sq_reg[NS].r12), 17'(sq_reg[NS].r11))
                                : pre(17'(sq_reg[NS].r21), 17'(sq_reg[NS].r22));
            cb_reg[0] <= pre(-17'(sq_reg[NS].r20), sy_w);
            cc_reg[0] <= pre(17'(sq_reg[NS].r10), 17'(sq_reg[NS].r00));
            for (int s = 0; s < rme_pkg::STEPS; s++)
            begin
                ca_reg[s+1]   <= ca_next[s];
                cb_reg[s+1]   <= cb_next[s];
                cc_reg[s+1]   <= cc_next[s];
                sing_reg[s+1] <= sing_reg[s];
            end
        end
    end

    for (genvar s = 0; s < rme_pkg::STEPS; s++)
    begin : g_cordic
        rme_cordic_step #(.IDX(4'(s))) u_a (.d(ca_reg[s]), .q(ca_next[s]));
        rme_cordic_step #(.IDX(4'(s))) u_b (.d(cb_reg[s]), .q(cb_next[s]));
        rme_cordic_step #(.IDX(4'(s))) u_c (.d(cc_reg[s]), .q(cc_next[s]));
    end

    function automatic logic signed [15:0] fin(input rme_pkg::cordic_t c,
                                               input logic signed [33:0] lim);
        logic signed [33:0] r;
        r = (c.acc + 34'sd65536) >>> 17;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        if (c.zero)
            r = '0;
        return r[15:0];
    endfunction

    logic signed [15:0] ay_full;
    assign ay_full = fin(cb_reg[rme_pkg::STEPS], rme_pkg::LIM_Y);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ax_reg       <= fin(ca_reg[rme_pkg::STEPS], rme_pkg::LIM_XZ);
            ay_reg       <= ay_full[14:0];
            az_reg       <= sing_reg[rme_pkg::STEPS] ? 16'sd0
                            : fin(cc_reg[rme_pkg::STEPS], rme_pkg::LIM_XZ);
            sing_out_reg <= sing_reg[rme_pkg::STEPS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg     <= {vld_reg[ND-2:0], in_ch.valid};
            out_vld_reg <= vld_reg[ND-1];
        end
    end

    assign out_ch.valid         = out_vld_reg;
    assign out_ch.angle_x       = ax_reg;
    assign out_ch.angle_y       = ay_reg;
    assign out_ch.angle_z       = az_reg;
    assign out_ch.singular_flag = sing_out_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ch.ready |=> out_vld_reg && $stable(ax_reg))
        else $error("output changed under stall");
    a_z: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && sing_out_reg |-> az_reg == 16'sd0)
        else $error("angle_z nonzero in gimbal lock");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> in_ch.ready)
        else $error("input stalled with empty output");
endmodule
